### sv/ecal_pkg.sv
`timescale 1ns / 1ps

package ecal_pkg;

  // Word widths
  localparam int COUNT_W = 32;
  localparam int DAYS_W  = 16;
  localparam int TOD_W   = 17;

  // Register stages from the accepting edge to the strobe
  localparam int PIPE_DEPTH = 10;

  // Stages that the time-of-day word waits for the date path
  localparam int TIME_DELAY = 4;

  // Divide by 86400 as a shift by 7 and a divide by 675
  localparam logic [15:0] RECIP_675  = 16'd49710;   // floor(2^25 / 675)
  localparam logic [9:0]  DIV_675    = 10'd675;

  // Time-of-day and weekday reciprocals
  localparam logic [11:0] RECIP_60   = 12'd2184;    // floor(2^17 / 60)
  localparam logic [5:0]  RECIP_3600 = 6'd36;       // floor(2^17 / 3600)
  localparam logic [13:0] RECIP_7    = 14'd9362;    // floor(2^16 / 7)
  localparam logic [5:0]  DIV_60     = 6'd60;
  localparam logic [11:0] DIV_3600   = 12'd3600;
  localparam logic [2:0]  DIV_7      = 3'd7;

  // Epoch day 0 is a Thursday: JDN 2440588 mod 7 = 3
  localparam logic [1:0]  WDAY_BIAS  = 2'd3;

  // 4 * (2440588 + 32044) + 3
  localparam logic [23:0] XB_OFFSET  = 24'd9890531;

  // 400-year cycle limits: 146097 * 68 and 146097 * 69
  localparam logic [23:0] CYC_EDGE_1 = 24'd9934596;
  localparam logic [23:0] CYC_EDGE_2 = 24'd10080693;

  // Four-year cycle
  localparam logic [9:0]  RECIP_1461 = 10'd717;     // floor(2^20 / 1461)
  localparam logic [10:0] DIV_1461   = 11'd1461;

  // Month span
  localparam logic [3:0]  RECIP_153  = 4'd13;       // floor(2^11 / 153)
  localparam logic [7:0]  DIV_153    = 8'd153;
  localparam logic [3:0]  MONTH_WRAP = 4'd10;

  // 100 * 67 - 4800
  localparam logic [11:0] YEAR_ORIGIN = 12'd1900;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } time_word_t;

  // 146097 * (67 + offset): start of the 400-year cycle in the 4a+3 scale
  function automatic logic [23:0] cycle_base(input logic [1:0] bo);
    logic [23:0] base;
    case (bo)
      2'd0:    base = 24'd9788499;
      2'd1:    base = 24'd9934596;
      2'd2:    base = 24'd10080693;
      default: base = 24'd10080693;
    endcase
    return base;
  endfunction

  // (153 * m + 2) / 5: day offset of a March-based month
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] ms;
    case (m)
      4'd0:    ms = 9'd0;
      4'd1:    ms = 9'd31;
      4'd2:    ms = 9'd61;
      4'd3:    ms = 9'd92;
      4'd4:    ms = 9'd122;
      4'd5:    ms = 9'd153;
      4'd6:    ms = 9'd184;
      4'd7:    ms = 9'd214;
      4'd8:    ms = 9'd245;
      4'd9:    ms = 9'd275;
      4'd10:   ms = 9'd306;
      4'd11:   ms = 9'd337;
      default: ms = 9'd0;
    endcase
    return ms;
  endfunction

  // 100 * offset of the century within the 400-year cycle
  function automatic logic [7:0] century_years(input logic [1:0] bo);
    logic [7:0] cy;
    case (bo)
      2'd0:    cy = 8'd0;
      2'd1:    cy = 8'd100;
      2'd2:    cy = 8'd200;
      default: cy = 8'd200;
    endcase
    return cy;
  endfunction

endpackage

### sv/epoch_seconds_to_calendar_date_core.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Word
// ------    ---------                 ----
// input     start, busy               seconds_count
// result    done (one-cycle strobe)   year, month, day_of_month,
//                                     hour, minute, second, weekday
//
// One word is taken at every edge where start is high and busy is low, so the converter
// sustains one word per clock. Each result is held on the ports for one cycle, after its
// word has passed the registered stages of the pipeline; the depth is set by the chain of
// reciprocal multiplies and correction steps in the date path. Synchronous reset drops
// every word in flight; busy is high only while reset is held. The receiver cannot stall,
// so nothing in the pipeline ever waits.
module epoch_seconds_to_calendar_date_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ecal_pkg::COUNT_W-1:0]  seconds_count,
  output logic                          done,
  output logic [11:0]                   year,
  output logic [3:0]                    month,
  output logic [4:0]                    day_of_month,
  output logic [4:0]                    hour,
  output logic [5:0]                    minute,
  output logic [5:0]                    second,
  output logic [2:0]                    weekday
);
  import ecal_pkg::*;

  // Refuse words only while reset is applied
  assign busy = rst;

  // Stage 1: capture the accepted word
  logic               v1;
  logic [COUNT_W-1:0] count1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    count1 <= seconds_count;
  end

  // Stages 2 and 3: whole days and second of the day
  logic              v3;
  logic [DAYS_W-1:0] days3;
  logic [TOD_W-1:0]  tod3;

  ecal_day_split u_day_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .count     (count1),
    .out_valid (v3),
    .days      (days3),
    .tod       (tod3)
  );

  // Stages 4 to 10: hour, minute, second and weekday, delayed to line up
  time_word_t tw;

  ecal_time_split u_time_split (
    .clk  (clk),
    .days (days3),
    .tod  (tod3),
    .tw   (tw)
  );

  // Stages 4 to 10: Gregorian date from the day count; carries the strobe
  ecal_civil_date u_civil_date (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (v3),
    .days         (days3),
    .out_valid    (done),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month)
  );

  assign hour    = tw.hour;
  assign minute  = tw.minute;
  assign second  = tw.second;
  assign weekday = tw.weekday;

endmodule

### sv/ecal_day_split.sv
`timescale 1ns / 1ps

module ecal_day_split (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [ecal_pkg::COUNT_W-1:0]  count,
  output logic                          out_valid,
  output logic [ecal_pkg::DAYS_W-1:0]   days,
  output logic [ecal_pkg::TOD_W-1:0]    tod
);
  import ecal_pkg::*;

  // Stage 2: reciprocal product of count / 128
  logic        v2;
  logic [24:0] xhi;
  logic [6:0]  lo7;
  logic [40:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= in_valid;
    end
    xhi  <= count[31:7];
    lo7  <= count[6:0];
    prod <= 41'(count[31:7]) * 41'(RECIP_675);
  end

  // Stage 3: estimate is low by at most one; correct once
  logic [15:0] q0;
  logic [25:0] back;
  logic [25:0] rem;
  logic [15:0] days_next;
  logic [9:0]  r_next;

  always_comb begin
    q0   = prod[40:25];
    back = 26'(q0) * 26'(DIV_675);
    rem  = {1'b0, xhi} - back;
    if (rem >= 26'(DIV_675)) begin
      days_next = q0 + 16'd1;
      r_next    = 10'(rem - 26'(DIV_675));
    end else begin
      days_next = q0;
      r_next    = rem[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    days <= days_next;
    tod  <= {r_next, lo7};
  end

endmodule

### sv/ecal_time_split.sv
`timescale 1ns / 1ps

module ecal_time_split (
  input  logic                         clk,
  input  logic [ecal_pkg::DAYS_W-1:0]  days,
  input  logic [ecal_pkg::TOD_W-1:0]   tod,
  output ecal_pkg::time_word_t         tw
);
  import ecal_pkg::*;

  // Stage 4: reciprocal products
  logic [16:0] tod4;
  logic [15:0] wx;
  logic [28:0] ptm;
  logic [22:0] phr;
  logic [29:0] pw;

  always_ff @(posedge clk) begin
    tod4 <= tod;
    wx   <= days + 16'(WDAY_BIAS);
    ptm  <= 29'(tod) * 29'(RECIP_60);
    phr  <= 23'(tod) * 23'(RECIP_3600);
    pw   <= 30'(days + 16'(WDAY_BIAS)) * 30'(RECIP_7);
  end

  // Stage 5: corrected quotients and remainders
  logic [10:0] tm0, tm_next;
  logic [16:0] rem_m;
  logic [5:0]  sec_next;
  logic [4:0]  h0, hour_next;
  logic [16:0] rem_h;
  logic [12:0] w0;
  logic [15:0] rem_w;
  logic [2:0]  wday_next;

  always_comb begin
    tm0   = ptm[27:17];
    rem_m = tod4 - 17'(tm0) * 17'(DIV_60);
    if (rem_m >= 17'(DIV_60)) begin
      tm_next  = tm0 + 11'd1;
      sec_next = 6'(rem_m - 17'(DIV_60));
    end else begin
      tm_next  = tm0;
      sec_next = rem_m[5:0];
    end

    h0    = phr[21:17];
    rem_h = tod4 - 17'(h0) * 17'(DIV_3600);
    hour_next = (rem_h >= 17'(DIV_3600)) ? h0 + 5'd1 : h0;

    w0    = pw[28:16];
    rem_w = wx - 16'(w0) * 16'(DIV_7);
    wday_next = (rem_w >= 16'(DIV_7)) ? 3'(rem_w - 16'(DIV_7)) : rem_w[2:0];
  end

  logic [10:0] tm5;
  logic [4:0]  hour5;
  logic [5:0]  sec5;
  logic [2:0]  wday5;

  always_ff @(posedge clk) begin
    tm5   <= tm_next;
    hour5 <= hour_next;
    sec5  <= sec_next;
    wday5 <= wday_next;
  end

  // Stage 6: minute from minute-of-day
  time_word_t tw6;
  logic [10:0] min_full;

  assign min_full = tm5 - 11'(hour5) * 11'(DIV_60);

  always_ff @(posedge clk) begin
    tw6.hour    <= hour5;
    tw6.minute  <= min_full[5:0];
    tw6.second  <= sec5;
    tw6.weekday <= wday5;
  end

  // Stages 7 to 10: hold in step with the date path
  time_word_t dly [TIME_DELAY];

  always_ff @(posedge clk) begin
    dly[0] <= tw6;
    for (int i = 1; i < TIME_DELAY; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  assign tw = dly[TIME_DELAY-1];

endmodule

### sv/ecal_civil_date.sv
`timescale 1ns / 1ps

module ecal_civil_date (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [ecal_pkg::DAYS_W-1:0]  days,
  output logic                         out_valid,
  output logic [11:0]                  year,
  output logic [3:0]                   month,
  output logic [4:0]                   day_of_month
);
  import ecal_pkg::*;

  logic v4, v5, v6, v7, v8, v9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      v9        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v4        <= in_valid;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      v8        <= v7;
      v9        <= v8;
      out_valid <= v9;
    end
  end

  // Stage 4: 4a + 3 with a = days + epoch JDN + 32044
  logic [23:0] xb;

  always_ff @(posedge clk) begin
    xb <= {6'd0, days, 2'b00} + XB_OFFSET;
  end

  // Stage 5: century cycle and day within it
  logic [1:0]  bo_next;
  logic [23:0] diff_b;
  logic [1:0]  bo5;
  logic [15:0] c5;

  always_comb begin
    bo_next = 2'(xb >= CYC_EDGE_1) + 2'(xb >= CYC_EDGE_2);
    diff_b  = xb - cycle_base(bo_next);
  end

  always_ff @(posedge clk) begin
    bo5 <= bo_next;
    c5  <= diff_b[17:2];
  end

  // Stage 6: reciprocal product for the four-year cycle
  logic [1:0]  bo6;
  logic [17:0] xd6;
  logic [27:0] pd6;

  always_ff @(posedge clk) begin
    bo6 <= bo5;
    xd6 <= {c5, 2'b11};
    pd6 <= 28'({c5, 2'b11}) * 28'(RECIP_1461);
  end

  // Stage 7: year within the cycle and day within the year
  logic [6:0]  dq0, d_next;
  logic [17:0] rem_d;
  logic [10:0] rd;
  logic [1:0]  bo7;
  logic [6:0]  d7;
  logic [8:0]  e7;

  always_comb begin
    dq0   = pd6[26:20];
    rem_d = xd6 - 18'(dq0) * 18'(DIV_1461);
    if (rem_d >= 18'(DIV_1461)) begin
      d_next = dq0 + 7'd1;
      rd     = 11'(rem_d - 18'(DIV_1461));
    end else begin
      d_next = dq0;
      rd     = rem_d[10:0];
    end
  end

  always_ff @(posedge clk) begin
    bo7 <= bo6;
    d7  <= d_next;
    e7  <= rd[10:2];
  end

  // Stage 8: reciprocal product for the month span
  logic [1:0]  bo8;
  logic [6:0]  d8;
  logic [8:0]  e8;
  logic [10:0] xm8;
  logic [14:0] pm8;
  logic [10:0] xm_next;

  assign xm_next = 11'(e7) * 11'd5 + 11'd2;

  always_ff @(posedge clk) begin
    bo8 <= bo7;
    d8  <= d7;
    e8  <= e7;
    xm8 <= xm_next;
    pm8 <= 15'(xm_next) * 15'(RECIP_153);
  end

  // Stage 9: March-based month
  logic [3:0]  mq0, m_next;
  logic [10:0] rem_m;
  logic [1:0]  bo9;
  logic [6:0]  d9;
  logic [8:0]  e9;
  logic [3:0]  m9;

  always_comb begin
    mq0    = pm8[14:11];
    rem_m  = xm8 - 11'(mq0) * 11'(DIV_153);
    m_next = (rem_m >= 11'(DIV_153)) ? mq0 + 4'd1 : mq0;
  end

  always_ff @(posedge clk) begin
    bo9 <= bo8;
    d9  <= d8;
    e9  <= e8;
    m9  <= m_next;
  end

  // Stage 10: fold back to January-based month and calendar year
  logic       carry;
  logic [8:0] mday_full;

  always_comb begin
    carry     = (m9 >= MONTH_WRAP);
    mday_full = e9 - month_start(m9) + 9'd1;
  end

  always_ff @(posedge clk) begin
    day_of_month <= mday_full[4:0];
    month        <= carry ? m9 - 4'd9 : m9 + 4'd3;
    year         <= YEAR_ORIGIN + 12'(century_years(bo9)) + 12'(d9) + 12'(carry);
  end

endmodule

### sv/ecal_checker.sv
`timescale 1ns / 1ps

module ecal_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [11:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day_of_month,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second,
  input logic [2:0]  weekday
);
  import ecal_pkg::*;

  // Reset drops every word in flight
  a_reset_clears : assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // Every accepted word gives its result after the fixed latency
  a_word_delivered : assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##PIPE_DEPTH done)
    else $error("accepted word produced no result");

  // No result without an accepted word at the matching edge
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without an accepted word");

  // Fields of a result stay within the calendar
  a_fields_legal : assert property (@(posedge clk) disable iff (rst)
    done |-> (year >= 12'd1970) && (year <= 12'd2106) &&
             (month >= 4'd1) && (month <= 4'd12) &&
             (day_of_month >= 5'd1) && (hour <= 5'd23) &&
             (minute <= 6'd59) && (second <= 6'd59) && (weekday <= 3'd6))
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_date_core ecal_checker u_ecal_checker (.*);

### test/tb_epoch_seconds_to_calendar_date_core.sv
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_date_core;

  import ecal_pkg::*;

  // Constants of the day-number to civil-date conversion
  localparam longint unsigned SECS_PER_DAY = 64'd86400;
  localparam longint unsigned EPOCH_JDN    = 64'd2440588;
  localparam longint unsigned JDN_SHIFT    = 64'd32044;
  localparam longint unsigned DAYS_400Y    = 64'd146097;
  localparam longint unsigned DAYS_4Y      = 64'd1461;
  localparam longint unsigned MONTH_SPAN   = 64'd153;
  localparam longint unsigned YEAR_SHIFT   = 64'd4800;

  // Last whole day that fits in a 32-bit count, and the size of the random part
  localparam int unsigned LAST_FULL_DAY = 49709;
  localparam int          RANDOM_WORDS  = 500;
  localparam int          CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } calendar_t;

  // One row of the directed table: when typed is set the date is given here,
  // otherwise it is worked out by the predictor
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               typed;
    calendar_t          date;
  } stim_row_t;

  localparam int DIR_ROWS = 22;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // the epoch itself, a Thursday
    '{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0,  6'd0,  6'd0,  3'd3}},
    // top of the second and minute fields
    '{32'd59,         1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0,  6'd0,  6'd59, 3'd3}},
    '{32'd3599,       1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0,  6'd59, 6'd59, 3'd3}},
    // last second of the first day, then the first of the next
    '{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 3'd3}},
    '{32'd86400,      1'b1, '{12'd1970, 4'd1, 5'd2, 5'd0,  6'd0,  6'd0,  3'd4}},
    // largest count: the day count must not wrap
    '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6,  6'd28, 6'd15, 3'd6}},
    '{32'd4294944000, 1'b0, '0},  // midnight of the last day
    '{32'd68169600,   1'b0, '0},  // first leap day after the epoch
    '{32'd946684799,  1'b0, '0},  // turn of the millennium
    '{32'd946684800,  1'b0, '0},
    '{32'd951782400,  1'b0, '0},  // leap day of a year divisible by 400
    '{32'd951868800,  1'b0, '0},
    '{32'd4102444800, 1'b0, '0},  // century year that is not a leap year
    '{32'd4107456000, 1'b0, '0},
    '{32'd4107542400, 1'b0, '0},
    '{32'h7FFF_FFFF,  1'b0, '0},  // either side of the top bit
    '{32'h8000_0000,  1'b0, '0},
    '{32'h5555_5555,  1'b0, '0},  // alternating bit patterns
    '{32'hAAAA_AAAA,  1'b0, '0},
    '{32'hFFFF_0000,  1'b0, '0},
    '{32'h0000_FFFF,  1'b0, '0},
    '{32'd1234567890, 1'b0, '0}
  };

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [COUNT_W-1:0] seconds_count;
  logic               done;
  logic [11:0]        year;
  logic [3:0]         month;
  logic [4:0]         day_of_month;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [5:0]         second;
  logic [2:0]         weekday;

  // Dates still owed by the converter, oldest first
  calendar_t dates_due [$];
  int        mismatches;
  int        cycle_count;

  epoch_seconds_to_calendar_date_core u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .seconds_count (seconds_count),
    .done          (done),
    .year          (year),
    .month         (month),
    .day_of_month  (day_of_month),
    .hour          (hour),
    .minute        (minute),
    .second        (second),
    .weekday       (weekday)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Split a count into time of day, take the Julian day number for the
  // weekday, and run the Julian-day-to-Gregorian steps for the date
  function automatic calendar_t civil_from_seconds(input logic [COUNT_W-1:0] count);
    longint unsigned secs, days, tod, jday, shifted, cycles, in_cycle;
    longint unsigned quads, in_year, march_month, carry;
    calendar_t       date;
    secs        = 64'(count);
    days        = secs / SECS_PER_DAY;
    tod         = secs - days * SECS_PER_DAY;
    jday        = days + EPOCH_JDN;
    shifted     = jday + JDN_SHIFT;
    cycles      = (4 * shifted + 3) / DAYS_400Y;
    in_cycle    = shifted - (DAYS_400Y * cycles) / 4;
    quads       = (4 * in_cycle + 3) / DAYS_4Y;
    in_year     = in_cycle - (DAYS_4Y * quads) / 4;
    march_month = (5 * in_year + 2) / MONTH_SPAN;
    carry       = march_month / 10;
    date.year         = 12'(100 * cycles + quads + carry - YEAR_SHIFT);
    date.month        = 4'(march_month + 3 - 12 * carry);
    date.day_of_month = 5'(in_year - (MONTH_SPAN * march_month + 2) / 5 + 1);
    date.hour         = 5'(tod / 3600);
    date.minute       = 6'((tod / 60) % 60);
    date.second       = 6'(tod % 60);
    date.weekday      = 3'(jday % 7);
    return date;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Offer one word after an idle gap and hold it until it is taken. Start is
  // left high on return, so a following word with no gap goes straight on.
  task automatic send_word(input logic [COUNT_W-1:0] value, input int gap,
                           input calendar_t date);
    if (gap > 0) begin
      start         <= 1'b0;
      seconds_count <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    seconds_count <= value;
    do @(posedge clk); while (busy);
    dates_due.push_back(date);
  endtask

  // Draw a count that lands in interesting places: anywhere, on either side of a
  // midnight, or close to the top of the range
  function automatic logic [COUNT_W-1:0] pick_count();
    longint unsigned day;
    logic [COUNT_W-1:0] count;
    case ($urandom_range(0, 3))
      0, 1: begin
        count = $urandom;
      end
      2: begin
        day   = 64'($urandom_range(0, LAST_FULL_DAY));
        count = 32'(day * SECS_PER_DAY + 64'($urandom_range(0, 1)) * 64'd86399
                    + 64'($urandom_range(0, 1)));
      end
      default: begin
        count = $urandom_range(32'hFFFF_FFFF, 32'hFFFC_0000);
      end
    endcase
    return count;
  endfunction

  // Results cannot be held off: take every strobed word and check it against
  // the oldest date still owed
  always @(posedge clk) begin
    calendar_t want;
    if (!rst && done) begin
      if (dates_due.size() == 0) begin
        $error("result word with no date pending: %0d-%0d-%0d %0d:%0d:%0d",
               year, month, day_of_month, hour, minute, second);
        mismatches++;
      end else begin
        want = dates_due.pop_front();
        compare_field("year",         32'(want.year),         32'(year));
        compare_field("month",        32'(want.month),        32'(month));
        compare_field("day_of_month", 32'(want.day_of_month), 32'(day_of_month));
        compare_field("hour",         32'(want.hour),         32'(hour));
        compare_field("minute",       32'(want.minute),       32'(minute));
        compare_field("second",       32'(want.second),       32'(second));
        compare_field("weekday",      32'(want.weekday),      32'(weekday));
      end
    end
  end

  // Watchdog: give up well past the slowest correct run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int                 gap;
    bit                 quiet;
    logic [COUNT_W-1:0] value;
    mismatches    = 0;
    rst           = 1'b1;
    start         = 1'b0;
    seconds_count = '0;

    // Hold reset, then release it on an edge
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table with random gaps between words
    for (int i = 0; i < DIR_ROWS; i++) begin
      gap = $urandom_range(0, 13);
      if (DIRECTED[i].typed)
        send_word(DIRECTED[i].count, gap, DIRECTED[i].date);
      else
        send_word(DIRECTED[i].count, gap, civil_from_seconds(DIRECTED[i].count));
    end

    // Random part: bursts of back-to-back words are mixed at random with bursts
    // where the sender idles for a random number of cycles per word
    quiet = 1'b0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 40 == 0) quiet = $urandom_range(0, 2) == 0;
      gap   = quiet ? 0 : $urandom_range(0, 13);
      value = pick_count();
      send_word(value, gap, civil_from_seconds(value));
    end
    start         <= 1'b0;
    seconds_count <= '0;

    // Drain the pipeline, then watch a little longer for stray strobes
    while (dates_due.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    if (mismatches == 0 && dates_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### epoch_seconds_to_calendar_date_core.f
sv/ecal_pkg.sv
sv/ecal_day_split.sv
sv/ecal_time_split.sv
sv/ecal_civil_date.sv
sv/epoch_seconds_to_calendar_date_core.sv
sv/ecal_checker.sv
test/tb_epoch_seconds_to_calendar_date_core.sv
